[rtl/core/sha1_pkg.sv]
// Package: SHA-1 engine types and constants.
package sha1_pkg;

   localparam logic [1:0] ACT_APPEND  = 2'd0;
   localparam logic [1:0] ACT_FINISH  = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_SEALED = 2'd1;
   localparam logic [1:0] ST_LIMIT  = 2'd2;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   localparam logic [63:0] LEN_LIMIT = 64'hFFFF_FFFF_FFFF_FFF7;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,     // write one pad byte a cycle into the buffer
      S_WLOAD,    // pack byte lanes into round word
      S_ROUND,    // one compression round a cycle
      S_ADD,      // fold working vars into chaining words
      S_EMIT,     // present digest words
      S_REJECT    // present rejection word
   } state_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      if (r < 7'd20)      return 32'h5A827999;
      else if (r < 7'd40) return 32'h6ED9EBA1;
      else if (r < 7'd60) return 32'h8F1BBCDC;
      else                return 32'hCA62C1D6;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      if (r < 7'd20)      return (b & c) | (~b & d);
      else if (r < 7'd40) return b ^ c ^ d;
      else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
      else                return b ^ c ^ d;
   endfunction

endpackage

[rtl/core/sha1_message_digest.sv]
// Top level: SHA-1 engine with byte input stream and digest word output.
//
// Input channel req_*: one word per action. tdata = {data_byte[9:2], action[1:0]}.
// Append stores a byte and gives no result; a full 64-byte block runs the
// compressor. Finish pads, compresses and returns five words (index 0..4,
// rsp_tlast on index 4). A repeated finish re-sends the stored digest.
// Restart reloads initial values. Rejected appends return one word with a
// nonzero status and rsp_tlast set.
// An append that fills a block goes on after the accept through packing
// buffer bytes via the registered read, the rounds and the fold. Finish
// writes pad bytes up to the end of the block, then compresses it; when
// the length does not fit, a second pad block is written and compressed.
// Then the five result words follow.
// The single round unit (adder chain, one round per cycle) sets the rate;
// req_tready is low while an item is in progress.
// Reset (synchronous, active high) returns to initial chaining values.
// A stalled receiver holds rsp_* stable; the engine waits until each word
// is taken.
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] action, [9:2] data_byte, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   sha1_pkg::state_type state_ff, state_in;

   logic [7:0]  buf_mem [64];
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  idx_ff;          // buffer fill / pad position
   logic [6:0]  rnd_ff;          // round or load counter
   logic [63:0] cnt_ff;
   logic        sealed_ff;
   logic        finishing_ff;    // compress is part of a finish
   logic        last_blk_ff;     // length goes into the current pad block
   logic [2:0]  widx_ff;
   logic [1:0]  rstat_ff;
   logic [7:0]  rd_ff;           // registered buffer read

   logic [1:0]  act;
   logic [7:0]  dbyte;
   logic        req_fire, rsp_fire;
   logic [31:0] t_val, wnew;
   logic [5:0]  rd_addr;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic        wr_en;
   logic [7:0]  pad_byte;

   assign act      = req_tdata[1:0];
   assign dbyte    = req_tdata[9:2];
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Outputs by state
   always_comb begin
      req_tready = (state_ff == sha1_pkg::S_IDLE);
      rsp_tvalid = (state_ff == sha1_pkg::S_EMIT) || (state_ff == sha1_pkg::S_REJECT);
      rsp_tdata  = '0;
      rsp_tlast  = 1'b1;
      rsp_tuser  = rstat_ff;
      if (state_ff == sha1_pkg::S_EMIT) begin
         rsp_tdata[31:0]  = h_ff[widx_ff];
         rsp_tdata[34:32] = widx_ff;
         rsp_tlast        = (widx_ff == 3'd4);
      end
   end

   // Pad byte at position idx_ff during S_LOAD; the marker bit flags the 0x80 byte
   always_comb begin
      pad_byte = 8'h00;
      if (idx_ff[6])
         pad_byte = sha1_pkg::PAD_BYTE;
      else if (idx_ff[5:0] >= 6'd56 && last_blk_ff)
         pad_byte = cnt_ff[8'd63 - {idx_ff[2:0], 3'b000} -: 8];
   end

   // Round word: first 16 from packed buffer, then message schedule
   assign wnew  = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]};
   assign t_val = {a_ff[26:0], a_ff[31:27]}
                + sha1_pkg::round_f(rnd_ff, b_ff, c_ff, d_ff)
                + e_ff + w_ff[0] + sha1_pkg::round_k(rnd_ff);

   assign rd_addr = rnd_ff[5:0];

   // Buffer write select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[5:0];
      wr_data = dbyte;
      if (state_ff == sha1_pkg::S_IDLE && req_fire && act == sha1_pkg::ACT_APPEND &&
          !sealed_ff && cnt_ff < sha1_pkg::LEN_LIMIT) begin
         wr_en = 1'b1;
      end else if (state_ff == sha1_pkg::S_LOAD) begin
         wr_en   = 1'b1;
         wr_data = pad_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[wr_addr] <= wr_data;
      rd_ff <= buf_mem[rd_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha1_pkg::S_IDLE: begin
            if (req_fire) begin
               case (act)
                  sha1_pkg::ACT_APPEND: begin
                     if (sealed_ff || cnt_ff >= sha1_pkg::LEN_LIMIT)
                        state_in = sha1_pkg::S_REJECT;
                     else if (idx_ff[5:0] == 6'd63)
                        state_in = sha1_pkg::S_WLOAD;
                  end
                  sha1_pkg::ACT_FINISH:
                     state_in = sealed_ff ? sha1_pkg::S_EMIT : sha1_pkg::S_LOAD;
                  default: state_in = sha1_pkg::S_IDLE;
               endcase
            end
         end
         sha1_pkg::S_LOAD:
            if (idx_ff[5:0] == 6'd63) state_in = sha1_pkg::S_WLOAD;
         sha1_pkg::S_WLOAD:
            if (rnd_ff == 7'd64) state_in = sha1_pkg::S_ROUND;
         sha1_pkg::S_ROUND:
            if (rnd_ff == 7'd79) state_in = sha1_pkg::S_ADD;
         sha1_pkg::S_ADD:
            if (!finishing_ff)     state_in = sha1_pkg::S_IDLE;
            else if (last_blk_ff)  state_in = sha1_pkg::S_EMIT;
            else                   state_in = sha1_pkg::S_LOAD;
         sha1_pkg::S_EMIT:
            if (rsp_fire && widx_ff == 3'd4) state_in = sha1_pkg::S_IDLE;
         sha1_pkg::S_REJECT:
            if (rsp_fire) state_in = sha1_pkg::S_IDLE;
         default: state_in = sha1_pkg::S_IDLE;
      endcase
   end

   // Datapath and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1_pkg::S_IDLE;
         h_ff[0]      <= sha1_pkg::H0;
         h_ff[1]      <= sha1_pkg::H1;
         h_ff[2]      <= sha1_pkg::H2;
         h_ff[3]      <= sha1_pkg::H3;
         h_ff[4]      <= sha1_pkg::H4;
         idx_ff       <= '0;
         rnd_ff       <= '0;
         cnt_ff       <= '0;
         sealed_ff    <= 1'b0;
         finishing_ff <= 1'b0;
         last_blk_ff  <= 1'b0;
         widx_ff      <= '0;
         rstat_ff     <= sha1_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            sha1_pkg::S_IDLE: begin
               rnd_ff  <= '0;
               widx_ff <= '0;
               if (req_fire) begin
                  case (act)
                     sha1_pkg::ACT_APPEND: begin
                        if (sealed_ff) rstat_ff <= sha1_pkg::ST_SEALED;
                        else if (cnt_ff >= sha1_pkg::LEN_LIMIT)
                           rstat_ff <= sha1_pkg::ST_LIMIT;
                        else begin
                           rstat_ff     <= sha1_pkg::ST_OK;
                           idx_ff       <= {1'b0, idx_ff[5:0] + 6'd1};
                           cnt_ff       <= cnt_ff + 64'd8;
                           finishing_ff <= 1'b0;
                        end
                     end
                     sha1_pkg::ACT_FINISH: begin
                        rstat_ff <= sha1_pkg::ST_OK;
                        if (!sealed_ff) begin
                           finishing_ff <= 1'b1;
                           last_blk_ff  <= (idx_ff[5:0] < 6'd56);
                           // first pad cycle writes 0x80 below via idx marker
                           idx_ff       <= {1'b1, idx_ff[5:0]};
                        end
                     end
                     sha1_pkg::ACT_RESTART: begin
                        h_ff[0]   <= sha1_pkg::H0;
                        h_ff[1]   <= sha1_pkg::H1;
                        h_ff[2]   <= sha1_pkg::H2;
                        h_ff[3]   <= sha1_pkg::H3;
                        h_ff[4]   <= sha1_pkg::H4;
                        idx_ff    <= '0;
                        cnt_ff    <= '0;
                        sealed_ff <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            sha1_pkg::S_LOAD: begin
               idx_ff <= {1'b0, idx_ff[5:0] + 6'd1};
               rnd_ff <= '0;
            end
            sha1_pkg::S_WLOAD: begin
               // rd_ff holds byte rnd_ff-1; shift into the word array
               rnd_ff <= (rnd_ff == 7'd64) ? 7'd0 : rnd_ff + 7'd1;
               if (rnd_ff != 7'd0) begin
                  w_ff[15] <= {w_ff[15][23:0], rd_ff};
                  // w_ff[15] holds a whole word in the cycle after its fourth byte shifts in
                  if (rnd_ff[1:0] == 2'd1 && rnd_ff != 7'd1)
                     for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               end
               a_ff <= h_ff[0];
               b_ff <= h_ff[1];
               c_ff <= h_ff[2];
               d_ff <= h_ff[3];
               e_ff <= h_ff[4];
            end
            sha1_pkg::S_ROUND: begin
               e_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= {b_ff[1:0], b_ff[31:2]};
               b_ff <= a_ff;
               a_ff <= t_val;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= {wnew[30:0], wnew[31]};
               rnd_ff   <= rnd_ff + 7'd1;
            end
            sha1_pkg::S_ADD: begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               idx_ff  <= '0;
               if (finishing_ff) begin
                  if (last_blk_ff) begin
                     cnt_ff    <= '0;
                     sealed_ff <= 1'b1;
                  end else begin
                     last_blk_ff <= 1'b1;
                  end
               end
            end
            sha1_pkg::S_EMIT:
               if (rsp_fire) widx_ff <= widx_ff + 3'd1;
            default: ;
         endcase
      end
   end

   // Assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != sha1_pkg::S_IDLE |-> !req_tready)
      else $error("input taken while busy");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed under stall");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::S_ROUND |-> rnd_ff < 7'd80)
      else $error("round counter overrun");
   a_sealed_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::S_EMIT |-> sealed_ff)
      else $error("digest sent while unsealed");

endmodule
